[hdl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/pafl_pkg.sv]
package pafl_pkg;

   localparam int PAFL_TABLE_ENTRIES = 64;
   localparam int MS_PER_SECOND      = 1000;
   localparam int COUNT_MAX          = 127;
   localparam int WINDOW_MS_W        = 26;  // 65535 s * 1000 fits in 26 bits

   localparam logic [1:0] CMD_CHECK = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_PRUNE = 2'd2;

   localparam logic CSR_ATTEMPT_LIMIT  = 1'b0;
   localparam logic CSR_WINDOW_SECONDS = 1'b1;

   localparam logic [7:0]             LIMIT_RESET     = 8'd5;
   localparam logic [WINDOW_MS_W-1:0] WINDOW_MS_RESET = 26'd60000;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic [6:0] matching_count;
      logic       add_dropped;
      logic [6:0] removed_count;
      logic [6:0] entries_in_use;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [47:0] stamp;
   } entry_type;

   function automatic logic [6:0] sat_count(input logic [31:0] n);
      sat_count = (n > 32'(COUNT_MAX)) ? 7'(COUNT_MAX) : n[6:0];
   endfunction

endpackage

[hdl/pafl_ram.sv]
module pafl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/per_address_flood_limiter.sv]
// Check and prune read every entry once; the result is registered as the last entry is
// processed, and the next item can be taken only after that, once busy has dropped.
// Add scans to the lowest free entry and stops at it; a full table or an unused
// command code is answered from idle without a scan. The table RAM has a single read port.
// Reset: busy stays high during a pass that writes zero to every entry, clearing every valid bit.
// Results are one-cycle strobes; the receiver cannot stall them.
`include "assert_macros.svh"

module per_address_flood_limiter
   import pafl_pkg::*;
#(
   parameter int TABLE_ENTRIES = PAFL_TABLE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int EW = $bits(entry_type);
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

   state_type state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [63:0] key_high_ff, key_high_in;
   logic [63:0] key_low_ff, key_low_in;
   logic [47:0] now_ff, now_in;
   logic [CW-1:0] issue_cnt_ff, issue_cnt_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] hit_cnt_ff, hit_cnt_in;
   logic [CW-1:0] in_use_ff, in_use_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [7:0]             limit_ff;
   logic [WINDOW_MS_W-1:0] window_ms_ff;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   entry_type     ram_wdata;
   logic [AW-1:0] ram_raddr;
   entry_type     rd_entry;
   logic [EW-1:0] ram_rdata;

   logic        key_match;
   logic [48:0] expiry;
   logic        expired;
   logic        last_rd;

   pafl_ram #(
      .WIDTH(EW),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_entry  = entry_type'(ram_rdata);
   assign ram_raddr = issue_cnt_ff[AW-1:0];

   assign key_match = rd_entry.valid && (rd_entry.key_high == key_high_ff) &&
                      (rd_entry.key_low == key_low_ff);
   // stamp + window formed one bit wider so it never wraps
   assign expiry    = {1'b0, rd_entry.stamp} + 49'(window_ms_ff);
   assign expired   = rd_entry.valid && (expiry < {1'b0, now_ff});
   assign last_rd   = (rd_idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         window_ms_ff <= WINDOW_MS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ATTEMPT_LIMIT:  limit_ff <= csr_wdata[7:0];
            CSR_WINDOW_SECONDS: window_ms_ff <= WINDOW_MS_W'(csr_wdata) *
                                                WINDOW_MS_W'(MS_PER_SECOND);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_cnt_ff <= '0;
         rd_pend_ff   <= 1'b0;
         hit_cnt_ff   <= '0;
         in_use_ff    <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         hit_cnt_ff   <= hit_cnt_in;
         in_use_ff    <= in_use_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_high_ff <= key_high_in;
      key_low_ff  <= key_low_in;
      now_ff      <= now_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_high_in  = key_high_ff;
      key_low_in   = key_low_ff;
      now_in       = now_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hit_cnt_in   = hit_cnt_ff;
      in_use_in    = in_use_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      ram_we       = 1'b0;
      ram_waddr    = rd_idx_ff;
      ram_wdata    = rd_entry;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_ff;
            ram_wdata = '0;
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               cmd_in       = req_data.command;
               key_high_in  = req_data.address_high;
               key_low_in   = req_data.address_low;
               now_in       = req_data.now_ms;
               issue_cnt_in = '0;
               hit_cnt_in   = '0;
               rsp_in.entries_in_use = sat_count(32'(in_use_ff));
               case (req_data.command)
                  CMD_CHECK, CMD_PRUNE: state_in = ST_SCAN;
                  CMD_ADD: begin
                     if (in_use_ff == FULL_CNT) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.add_dropped = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end

         ST_SCAN: begin
            if (issue_cnt_ff < FULL_CNT) begin
               rd_pend_in   = 1'b1;
               rd_idx_in    = issue_cnt_ff[AW-1:0];
               issue_cnt_in = issue_cnt_ff + CW'(1);
            end
            if (rd_pend_ff) begin
               case (cmd_ff)
                  CMD_CHECK: begin
                     if (key_match) begin
                        hit_cnt_in = hit_cnt_ff + CW'(1);
                     end
                     if (last_rd) begin
                        state_in              = ST_IDLE;
                        rsp_valid_in          = 1'b1;
                        rsp_in.allowed        = (32'(hit_cnt_in) < 32'(limit_ff));
                        rsp_in.matching_count = sat_count(32'(hit_cnt_in));
                        rsp_in.entries_in_use = sat_count(32'(in_use_ff));
                     end
                  end
                  CMD_ADD: begin
                     // first free entry wins; later reads in flight are dropped
                     if (!rd_entry.valid) begin
                        ram_we             = 1'b1;
                        ram_wdata.valid    = 1'b1;
                        ram_wdata.key_high = key_high_ff;
                        ram_wdata.key_low  = key_low_ff;
                        ram_wdata.stamp    = now_ff;
                        in_use_in          = in_use_ff + CW'(1);
                        state_in           = ST_IDLE;
                        rsp_valid_in       = 1'b1;
                        rsp_in.entries_in_use = sat_count(32'(in_use_in));
                     end else if (last_rd) begin
                        state_in              = ST_IDLE;
                        rsp_valid_in          = 1'b1;
                        rsp_in.add_dropped    = 1'b1;
                        rsp_in.entries_in_use = sat_count(32'(in_use_ff));
                     end
                  end
                  CMD_PRUNE: begin
                     if (expired) begin
                        ram_we          = 1'b1;
                        ram_wdata.valid = 1'b0;
                        hit_cnt_in      = hit_cnt_ff + CW'(1);
                        in_use_in       = in_use_ff - CW'(1);
                     end
                     if (last_rd) begin
                        state_in              = ST_IDLE;
                        rsp_valid_in          = 1'b1;
                        rsp_in.removed_count  = sat_count(32'(hit_cnt_in));
                        rsp_in.entries_in_use = sat_count(32'(in_use_in));
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_CLK(a_rsp_only_idle, !rsp_valid_ff || (state_ff == ST_IDLE), "result outside idle")
   `ASSERT_CLK(a_in_use_bound, in_use_ff <= FULL_CNT, "entry count above table size")
   `ASSERT_CLK(a_no_rw_clash, !(ram_we && (state_ff == ST_SCAN) && (ram_raddr == ram_waddr)), "table read and write hit the same entry")
   `ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_valid_ff, "accepted item neither scanning nor answered")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import pafl_pkg::*;

   localparam logic [1:0]  CMD_UNUSED    = 2'd3;
   localparam int          N_ENTRIES     = PAFL_TABLE_ENTRIES;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          SEGMENT_ITEMS = 283;
   localparam int          POOL_SIZE     = 6;
   localparam logic [47:0] NOW_MAX       = '1;
   localparam logic [63:0] KEY_ZERO      = '0;
   localparam logic [63:0] KEY_ONES      = '1;
   localparam logic [63:0] KEY_A         = 64'h0F0F_0F0F_0F0F_0F0F;
   localparam logic [63:0] KEY_B         = 64'hF0F0_F0F0_F0F0_F0F0;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   always #5 clock = ~clock;

   per_address_flood_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the attempt table and its settings
   logic        shadow_valid  [N_ENTRIES];
   logic [63:0] shadow_key_hi [N_ENTRIES];
   logic [63:0] shadow_key_lo [N_ENTRIES];
   logic [47:0] shadow_stamp  [N_ENTRIES];
   logic [7:0]  limit_shadow;
   logic [15:0] window_shadow;

   rsp_type     replies_due [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          gap_pct = 0;

   logic [63:0] pool_hi [POOL_SIZE];
   logic [63:0] pool_lo [POOL_SIZE];
   logic [47:0] wall_ms;

   function automatic logic [6:0] clip_count(int n);
      return (n > COUNT_MAX) ? 7'(COUNT_MAX) : 7'(n);
   endfunction

   function automatic rsp_type predict_reply(req_type item);
      rsp_type     reply;
      int          hits;
      int          in_use;
      int          slot;
      logic [63:0] window_ms;
      reply = '0;
      hits = 0;
      in_use = 0;
      slot = -1;
      window_ms = 64'(window_shadow) * 64'(MS_PER_SECOND);
      case (item.command)
         CMD_CHECK: begin
            for (int i = 0; i < N_ENTRIES; i++)
               if (shadow_valid[i] && shadow_key_hi[i] == item.address_high &&
                   shadow_key_lo[i] == item.address_low)
                  hits++;
            reply.allowed = (hits < int'(limit_shadow));
            reply.matching_count = clip_count(hits);
         end
         CMD_ADD: begin
            for (int i = 0; i < N_ENTRIES && slot < 0; i++)
               if (!shadow_valid[i])
                  slot = i;
            if (slot < 0) begin
               reply.add_dropped = 1'b1;
            end else begin
               shadow_valid[slot] = 1'b1;
               shadow_key_hi[slot] = item.address_high;
               shadow_key_lo[slot] = item.address_low;
               shadow_stamp[slot] = item.now_ms;
            end
         end
         CMD_PRUNE: begin
            // 64-bit sum: expiry past the 48-bit range must not wrap
            for (int i = 0; i < N_ENTRIES; i++)
               if (shadow_valid[i] && 64'(shadow_stamp[i]) + window_ms < 64'(item.now_ms)) begin
                  shadow_valid[i] = 1'b0;
                  hits++;
               end
            reply.removed_count = clip_count(hits);
         end
         default: ;
      endcase
      for (int i = 0; i < N_ENTRIES; i++)
         if (shadow_valid[i])
            in_use++;
      reply.entries_in_use = clip_count(in_use);
      return reply;
   endfunction

   function automatic void compare_field(string label, logic [6:0] want_v, logic [6:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected reply: expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = replies_due.pop_front();
            compare_field("allowed", 7'(want.allowed), 7'(rsp_data.allowed));
            compare_field("matching_count", want.matching_count, rsp_data.matching_count);
            compare_field("add_dropped", 7'(want.add_dropped), 7'(rsp_data.add_dropped));
            compare_field("removed_count", want.removed_count, rsp_data.removed_count);
            compare_field("entries_in_use", want.entries_in_use, rsp_data.entries_in_use);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic req_type make_req(logic [1:0] cmd, logic [63:0] key_hi,
                                        logic [63:0] key_lo, logic [47:0] now);
      req_type item;
      item.command = cmd;
      item.address_high = key_hi;
      item.address_low = key_lo;
      item.now_ms = now;
      return item;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic issue_command(input req_type item);
      start = 1'b1;
      req_data = item;
      while (busy)
         @(negedge clock);
      @(posedge clock);
      replies_due.push_back(predict_reply(item));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic sender_gap();
      while ($urandom_range(99) < gap_pct)
         @(negedge clock);
   endtask

   task automatic wait_for_replies();
      while (replies_due.size() != 0)
         @(negedge clock);
      repeat (N_ENTRIES + 4) @(negedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [15:0] value);
      while (busy)
         @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_ATTEMPT_LIMIT)
         limit_shadow = value[7:0];
      else
         window_shadow = value;
   endtask

   task automatic test_empty_and_unused();
      issue_command(make_req(CMD_CHECK, KEY_ZERO, KEY_ZERO, '0));
      issue_command(make_req(CMD_PRUNE, KEY_ZERO, KEY_ZERO, '0));
      issue_command(make_req(CMD_UNUSED, KEY_ONES, KEY_ONES, NOW_MAX));
      wait_for_replies();
   endtask

   task automatic test_attempt_limit();
      repeat (5) issue_command(make_req(CMD_ADD, KEY_ONES, KEY_ONES, '0));
      // count equal to the default limit: refused
      issue_command(make_req(CMD_CHECK, KEY_ONES, KEY_ONES, '0));
      issue_command(make_req(CMD_CHECK, KEY_ONES, KEY_ZERO, '0));
      issue_command(make_req(CMD_CHECK, KEY_ZERO, KEY_ZERO, '0));
      wait_for_replies();
      write_register(CSR_ATTEMPT_LIMIT, {8'hA5, 8'd0});
      issue_command(make_req(CMD_CHECK, KEY_ZERO, KEY_ZERO, '0));
      wait_for_replies();
      write_register(CSR_ATTEMPT_LIMIT, {8'h5A, 8'hFF});
      issue_command(make_req(CMD_CHECK, KEY_ONES, KEY_ONES, '0));
      wait_for_replies();
   endtask

   task automatic test_prune_boundary();
      write_register(CSR_WINDOW_SECONDS, 16'd0);
      issue_command(make_req(CMD_ADD, KEY_ZERO, KEY_ZERO, 48'd100));
      // expiry equal to now: kept
      issue_command(make_req(CMD_PRUNE, KEY_ZERO, KEY_ZERO, 48'd100));
      issue_command(make_req(CMD_PRUNE, KEY_ZERO, KEY_ZERO, 48'd101));
      wait_for_replies();
      write_register(CSR_WINDOW_SECONDS, 16'hFFFF);
      issue_command(make_req(CMD_ADD, KEY_A, KEY_B, NOW_MAX));
      issue_command(make_req(CMD_PRUNE, KEY_A, KEY_B, NOW_MAX));
      issue_command(make_req(CMD_CHECK, KEY_A, KEY_B, NOW_MAX));
      wait_for_replies();
      write_register(CSR_WINDOW_SECONDS, 16'd0);
      issue_command(make_req(CMD_PRUNE, KEY_B, KEY_A, NOW_MAX));
      issue_command(make_req(CMD_ADD, KEY_B, KEY_A, NOW_MAX - 48'd1));
      issue_command(make_req(CMD_PRUNE, KEY_B, KEY_A, NOW_MAX));
      wait_for_replies();
      write_register(CSR_ATTEMPT_LIMIT, 16'(LIMIT_RESET));
      write_register(CSR_WINDOW_SECONDS, 16'(WINDOW_MS_RESET / MS_PER_SECOND));
   endtask

   function automatic req_type next_random_item();
      req_type item;
      int      k;
      int      pick;
      if ($urandom_range(99) < 8) begin
         item.command = 2'($urandom_range(3));
         item.address_high = {$urandom, $urandom};
         item.address_low = {$urandom, $urandom};
         item.now_ms = {16'($urandom), $urandom};
      end else begin
         k = $urandom_range(POOL_SIZE - 1);
         pick = $urandom_range(99);
         wall_ms += 48'($urandom_range(400));
         item.address_high = pool_hi[k];
         item.address_low = pool_lo[k];
         item.now_ms = wall_ms;
         item.command = (pick < 45) ? CMD_ADD : (pick < 85) ? CMD_CHECK : CMD_PRUNE;
      end
      return item;
   endfunction

   task automatic configure_segment(input int seg);
      logic [7:0]  lim;
      logic [15:0] win;
      case (seg)
         0: begin lim = 8'($urandom_range(1, 8)); win = 16'($urandom_range(3)); end
         1: begin lim = 8'($urandom_range(1, 8)); win = 16'hFFFF; end
         2: begin lim = 8'd0; win = 16'($urandom_range(1, 4)); end
         3: begin lim = 8'hFF; win = 16'hFFFF; end
         4: begin lim = 8'($urandom); win = 16'($urandom); end
         default: begin lim = 8'($urandom_range(2, 6)); win = 16'($urandom_range(2)); end
      endcase
      // upper data bits are junk for the 8-bit limit register
      write_register(CSR_ATTEMPT_LIMIT, {8'($urandom), lim});
      write_register(CSR_WINDOW_SECONDS, win);
      // odd pool slots sometimes share the high half, so both halves must match
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_hi[k] = (k % 2 == 1 && $urandom_range(1) == 1) ? pool_hi[k - 1]
                                                            : {$urandom, $urandom};
         pool_lo[k] = {$urandom, $urandom};
      end
   endtask

   task automatic test_random_traffic(input int pct, input int first_seg);
      req_type item;
      int      accepted;
      gap_pct = pct;
      for (int seg = first_seg; seg < first_seg + 2; seg++) begin
         configure_segment(seg);
         accepted = 0;
         while (accepted < SEGMENT_ITEMS) begin
            item = next_random_item();
            issue_command(item);
            if (item.command != CMD_UNUSED)
               accepted++;
            sender_gap();
         end
         wait_for_replies();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_ATTEMPT_LIMIT;
      csr_wdata = '0;
      for (int i = 0; i < N_ENTRIES; i++)
         shadow_valid[i] = 1'b0;
      limit_shadow = LIMIT_RESET;
      window_shadow = 16'(WINDOW_MS_RESET / MS_PER_SECOND);
      // start high so most noise stamps fall behind traffic time and expire
      wall_ms = {16'($urandom_range(16'hFF00, 16'hFFF0)), $urandom};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_empty_and_unused();
      test_attempt_limit();
      test_prune_boundary();
      test_random_traffic(17, 0);
      test_random_traffic(87, 2);
      test_random_traffic(0, 4);

      wait_for_replies();
      if (error_count == 0 && replies_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
